[rtl/spie_pkg.sv]
// Package with the word types, relation codes and status codes of the sib-pair IBD estimator.
`timescale 1ns / 1ps
`default_nettype none

package spie_pkg;

  // Widths fixed by the genotype and result formats.
  localparam int unsigned AlleleW   = 8;
  localparam int unsigned RelationW = 3;
  localparam int unsigned QuarterW  = 3;
  localparam int unsigned StatusW   = 2;

  // Relation codes carried in the input word.
  localparam logic [RelationW-1:0] REL_SELF          = 3'd0;
  localparam logic [RelationW-1:0] REL_FOUNDERS      = 3'd1;
  localparam logic [RelationW-1:0] REL_FOUNDER_CHILD = 3'd2;
  localparam logic [RelationW-1:0] REL_SIBS          = 3'd3;

  // Status codes carried in the result word.
  typedef enum logic [StatusW-1:0] {
    ST_OK              = 2'd0,
    ST_EXTENDED        = 2'd1,
    ST_UNTYPED_PARENTS = 2'd2
  } status_e;

  // Probabilities in quarters.
  localparam logic [QuarterW-1:0] Q_ZERO = 3'd0;
  localparam logic [QuarterW-1:0] Q_ONE  = 3'd1;
  localparam logic [QuarterW-1:0] Q_HALF = 3'd2;
  localparam logic [QuarterW-1:0] Q_FULL = 3'd4;

  typedef logic [AlleleW-1:0] allele_t;

  // One input word: relation and the four genotypes.
  typedef struct packed {
    logic [RelationW-1:0] relation;
    allele_t              first_allele_a;
    allele_t              first_allele_b;
    allele_t              second_allele_a;
    allele_t              second_allele_b;
    allele_t              father_allele_a;
    allele_t              father_allele_b;
    allele_t              mother_allele_a;
    allele_t              mother_allele_b;
  } in_word_t;

  // One result word: the three sharing probabilities and a status.
  typedef struct packed {
    logic [QuarterW-1:0] share_none;
    logic [QuarterW-1:0] share_one;
    logic [QuarterW-1:0] share_two;
    logic [StatusW-1:0]  status;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/spie_rules.sv]
// Combinational IBD rules that turn one genotype word into one result word.
`timescale 1ns / 1ps
`default_nettype none

module spie_rules import spie_pkg::*; (
  input  in_word_t  word_i,
  output out_word_t result_o
);

  allele_t pa, pb, qa, qb, fa, fb, ma, mb;
  logic    fa_typed, mo_typed, p_typed, q_typed;
  logic    fa_hom, mo_hom, p_hom, q_hom;
  allele_t unin;
  allele_t p_other, q_other;
  logic [1:0] ibs;
  allele_t shared;
  logic    shared_in_both, same_parents;

  assign pa = word_i.first_allele_a;
  assign pb = word_i.first_allele_b;
  assign qa = word_i.second_allele_a;
  assign qb = word_i.second_allele_b;
  assign fa = word_i.father_allele_a;
  assign fb = word_i.father_allele_b;
  assign ma = word_i.mother_allele_a;
  assign mb = word_i.mother_allele_b;

  // Typed and homozygous flags for each person.
  assign fa_typed = (fa != '0) && (fb != '0);
  assign mo_typed = (ma != '0) && (mb != '0);
  assign p_typed  = (pa != '0) && (pb != '0);
  assign q_typed  = (qa != '0) && (qb != '0);
  assign fa_hom   = (fa == fb);
  assign mo_hom   = (ma == mb);
  assign p_hom    = (pa == pb);
  assign q_hom    = (qa == qb);

  // The allele of the single homozygous parent, and each sib's other allele.
  assign unin    = fa_hom ? fa : ma;
  assign p_other = (pa == unin) ? pb : pa;
  assign q_other = (qa == unin) ? qb : qa;

  // Identity-by-state count between the sibs.
  always_comb begin
    if (pa == qa) begin
      ibs = (pb == qb) ? 2'd2 : 2'd1;
    end else if (pa == qb) begin
      ibs = (pb == qa) ? 2'd2 : 2'd1;
    end else begin
      ibs = ((pb == qa) || (pb == qb)) ? 2'd1 : 2'd0;
    end
  end

  // The allele shared by two heterozygous sibs, and whether both parents carry it.
  assign shared         = ((qa == pa) || (qb == pa)) ? pa : pb;
  assign shared_in_both = ((fa == shared) || (fb == shared)) &&
                          ((ma == shared) || (mb == shared));
  assign same_parents   = ((fa == ma) && (fb == mb)) || ((fa == mb) && (fb == ma));

  // Rule selection in the order of precedence.
  always_comb begin
    result_o.share_none = Q_ZERO;
    result_o.share_one  = Q_ZERO;
    result_o.share_two  = Q_ZERO;
    result_o.status     = ST_OK;
    if (word_i.relation == REL_SELF) begin
      result_o.share_two = Q_FULL;
    end else if (word_i.relation == REL_FOUNDERS) begin
      result_o.share_none = Q_FULL;
    end else if (word_i.relation == REL_FOUNDER_CHILD) begin
      result_o.share_one = Q_FULL;
    end else if (word_i.relation != REL_SIBS) begin
      result_o.status = ST_EXTENDED;
    end else if (!fa_typed || !mo_typed) begin
      result_o.status = ST_UNTYPED_PARENTS;
    end else if (!p_typed || !q_typed || (fa_hom && mo_hom)) begin
      result_o.share_none = Q_ONE;
      result_o.share_one  = Q_HALF;
      result_o.share_two  = Q_ONE;
    end else if (fa_hom || mo_hom) begin
      result_o.share_one = Q_HALF;
      if (p_other == q_other) begin
        result_o.share_two = Q_HALF;
      end else begin
        result_o.share_none = Q_HALF;
      end
    end else begin
      case (ibs)
        2'd0: begin
          result_o.share_none = Q_FULL;
        end
        2'd1: begin
          if (!p_hom && !q_hom && shared_in_both) begin
            result_o.share_none = Q_FULL;
          end else begin
            result_o.share_one = Q_FULL;
          end
        end
        default: begin
          if (p_hom || !same_parents) begin
            result_o.share_two = Q_FULL;
          end else begin
            result_o.share_none = Q_HALF;
            result_o.share_two  = Q_HALF;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sib_pair_ibd_estimate_top.sv]
// Top level of the sib-pair IBD estimator: input register, rule logic, result register.
//
// Usage: drive a genotype word on in_i and raise start_i. The word is taken at a
// rising edge where start_i is high and busy_o is low; busy_o is always low, so a
// new word can be taken in every cycle. Each word yields exactly one result word
// on result_o, marked by valid_o for one cycle, after it has passed the input
// register and then the result register. Throughput is one word per cycle; the
// rule logic between the two registers is a set of 8-bit equality compares and
// a priority select, which sets the cycle time.
// The receiver cannot stall; results are simply presented in order.
// Reset clears the valid flags of both stages, so no result is shown until a
// word has been taken after reset. There is no configuration.
`timescale 1ns / 1ps
`default_nettype none

module sib_pair_ibd_estimate_top import spie_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_word_t  in_i,
  output logic      valid_o,
  output out_word_t result_o
);

  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t res_d, res_q;
  logic      res_valid_q;

  assign busy_o = 1'b0;

  // Input stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= in_i;
    end
  end

  spie_rules u_rules (
    .word_i   (in_q),
    .result_o (res_d)
  );

  // Result stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the sib-pair IBD estimator: directed rules, then random genotypes.
`timescale 1ns / 1ps

module tb;
  import spie_pkg::*;

  localparam realtime ClkHalf    = 6ns;
  localparam int      ResetCycles = 12;
  localparam int      Latency     = 2;
  localparam int      IdleLimit   = 500;
  localparam int      ReportMax   = 10;

  // Relation codes that the package leaves unnamed.
  localparam logic [RelationW-1:0] REL_OTHER   = 3'd4;
  localparam logic [RelationW-1:0] REL_UNUSED7 = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  in_word_t  in_i = '0;
  logic      valid_o;
  out_word_t result_o;

  out_word_t expected_shares[$];
  out_word_t oldest_share;
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        word_moved;
  bit        no_gaps = 1'b0;

  sib_pair_ibd_estimate_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Expected sharing probabilities and status for one genotype word.
  function automatic out_word_t predict_ibd_shares(in_word_t w);
    out_word_t r;
    logic [AlleleW-1:0] hom_allele;
    logic [AlleleW-1:0] first_rest;
    logic [AlleleW-1:0] second_rest;
    logic [AlleleW-1:0] shared;
    int ibs;
    bit parents_typed;
    bit sibs_typed;
    r = '{share_none: Q_ZERO, share_one: Q_ZERO, share_two: Q_ZERO, status: ST_OK};
    hom_allele = '0;
    case (w.relation)
      REL_SELF: begin
        r.share_two = Q_FULL;
        return r;
      end
      REL_FOUNDERS: begin
        r.share_none = Q_FULL;
        return r;
      end
      REL_FOUNDER_CHILD: begin
        r.share_one = Q_FULL;
        return r;
      end
      REL_SIBS: ;
      default: begin
        r.status = ST_EXTENDED;
        return r;
      end
    endcase

    parents_typed = w.father_allele_a != 0 && w.father_allele_b != 0 &&
                    w.mother_allele_a != 0 && w.mother_allele_b != 0;
    sibs_typed = w.first_allele_a != 0 && w.first_allele_b != 0 &&
                 w.second_allele_a != 0 && w.second_allele_b != 0;
    if (!parents_typed) begin
      r.status = ST_UNTYPED_PARENTS;
      return r;
    end
    if (!sibs_typed) begin
      r = '{share_none: Q_ONE, share_one: Q_HALF, share_two: Q_ONE, status: ST_OK};
      return r;
    end

    // A homozygous parent passes the same allele to both sibs.
    if (w.father_allele_a == w.father_allele_b) hom_allele = w.father_allele_a;
    if (w.mother_allele_a == w.mother_allele_b) begin
      if (hom_allele != 0) begin
        r = '{share_none: Q_ONE, share_one: Q_HALF, share_two: Q_ONE, status: ST_OK};
        return r;
      end
      hom_allele = w.mother_allele_a;
    end
    if (hom_allele != 0) begin
      first_rest  = (w.first_allele_a == hom_allele) ? w.first_allele_b : w.first_allele_a;
      second_rest = (w.second_allele_a == hom_allele) ? w.second_allele_b : w.second_allele_a;
      if (first_rest == second_rest) begin
        r.share_one = Q_HALF;
        r.share_two = Q_HALF;
      end else begin
        r.share_none = Q_HALF;
        r.share_one  = Q_HALF;
      end
      return r;
    end

    // Both parents heterozygous: decide on identity by state.
    if (w.first_allele_a == w.second_allele_a)
      ibs = (w.first_allele_b == w.second_allele_b) ? 2 : 1;
    else if (w.first_allele_a == w.second_allele_b)
      ibs = (w.first_allele_b == w.second_allele_a) ? 2 : 1;
    else
      ibs = (w.first_allele_b == w.second_allele_a ||
             w.first_allele_b == w.second_allele_b) ? 1 : 0;

    if (ibs == 0) begin
      r.share_none = Q_FULL;
    end else if (ibs == 1) begin
      if (w.first_allele_a == w.first_allele_b || w.second_allele_a == w.second_allele_b) begin
        r.share_one = Q_FULL;
      end else begin
        shared = (w.second_allele_a == w.first_allele_a ||
                  w.second_allele_b == w.first_allele_a) ? w.first_allele_a : w.first_allele_b;
        if ((w.father_allele_a == shared || w.father_allele_b == shared) &&
            (w.mother_allele_a == shared || w.mother_allele_b == shared))
          r.share_none = Q_FULL;
        else
          r.share_one = Q_FULL;
      end
    end else begin
      if (w.first_allele_a == w.first_allele_b ||
          !((w.father_allele_a == w.mother_allele_a && w.father_allele_b == w.mother_allele_b) ||
            (w.father_allele_a == w.mother_allele_b && w.father_allele_b == w.mother_allele_a))) begin
        r.share_two = Q_FULL;
      end else begin
        r.share_none = Q_HALF;
        r.share_two  = Q_HALF;
      end
    end
    return r;
  endfunction

  function automatic in_word_t make_word(logic [RelationW-1:0] rel,
                                         int pa, int pb, int qa, int qb,
                                         int fa, int fb, int ma, int mb);
    in_word_t w;
    w.relation        = rel;
    w.first_allele_a  = AlleleW'(pa);
    w.first_allele_b  = AlleleW'(pb);
    w.second_allele_a = AlleleW'(qa);
    w.second_allele_b = AlleleW'(qb);
    w.father_allele_a = AlleleW'(fa);
    w.father_allele_b = AlleleW'(fb);
    w.mother_allele_a = AlleleW'(ma);
    w.mother_allele_b = AlleleW'(mb);
    return w;
  endfunction

  // Check each result against the oldest prediction, queue a prediction for
  // each accepted word, and stop the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_moved = 1'b0;
      if (valid_o === 1'b1) begin
        word_moved = 1'b1;
        if (expected_shares.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("Unexpected result word at %0t: none=%0d one=%0d two=%0d status=%0d",
                     $realtime, result_o.share_none, result_o.share_one,
                     result_o.share_two, result_o.status);
        end else begin
          oldest_share = expected_shares.pop_front();
          if (result_o.share_none !== oldest_share.share_none ||
              result_o.share_one !== oldest_share.share_one ||
              result_o.share_two !== oldest_share.share_two ||
              result_o.status !== oldest_share.status) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax)
              $display("Mismatch at %0t: expected %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                       $realtime,
                       oldest_share.share_none, oldest_share.share_one,
                       oldest_share.share_two, oldest_share.status,
                       result_o.share_none, result_o.share_one,
                       result_o.share_two, result_o.status);
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        word_moved = 1'b1;
        expected_shares.push_back(predict_ibd_shares(in_i));
      end
      idle_cycles = word_moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one word after a random gap; start stays high when no gap follows.
  task automatic send_word(in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_shares.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_fixed_relations();
    send_word(make_word(REL_SELF, 255, 255, 255, 255, 255, 255, 255, 255));
    send_word(make_word(REL_FOUNDERS, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REL_FOUNDER_CHILD, 1, 0, 128, 7, 0, 255, 64, 3));
    send_word(make_word(REL_OTHER, 5, 6, 5, 6, 5, 6, 5, 6));
    send_word(make_word(REL_UNUSED7, 255, 1, 2, 3, 4, 5, 6, 7));
  endtask

  task automatic test_untyped_family();
    // Untyped parents, then untyped sibs with typed parents.
    send_word(make_word(REL_SIBS, 1, 2, 1, 2, 0, 2, 3, 4));
    send_word(make_word(REL_SIBS, 1, 2, 1, 2, 1, 2, 3, 0));
    send_word(make_word(REL_SIBS, 1, 0, 1, 2, 1, 2, 3, 4));
    send_word(make_word(REL_SIBS, 1, 2, 0, 2, 1, 2, 3, 4));
  endtask

  task automatic test_homozygous_parents();
    send_word(make_word(REL_SIBS, 5, 9, 9, 5, 5, 5, 9, 9));
    // Father homozygous for 5: other alleles match, then differ.
    send_word(make_word(REL_SIBS, 5, 7, 7, 5, 5, 5, 7, 8));
    send_word(make_word(REL_SIBS, 5, 7, 5, 8, 5, 5, 7, 8));
    // Mother homozygous for 255.
    send_word(make_word(REL_SIBS, 3, 255, 4, 255, 3, 4, 255, 255));
    send_word(make_word(REL_SIBS, 3, 255, 255, 3, 3, 4, 255, 255));
  endtask

  task automatic test_state_sharing();
    send_word(make_word(REL_SIBS, 1, 3, 2, 4, 1, 2, 3, 4));
    send_word(make_word(REL_SIBS, 1, 1, 1, 3, 1, 2, 1, 3));
    // One shared allele carried by both parents, then by one only.
    send_word(make_word(REL_SIBS, 1, 2, 3, 1, 1, 2, 1, 3));
    send_word(make_word(REL_SIBS, 1, 3, 4, 1, 1, 2, 3, 4));
    // Two shared alleles: homozygous sibs, same parental genotype, differing.
    send_word(make_word(REL_SIBS, 1, 1, 1, 1, 1, 2, 1, 3));
    send_word(make_word(REL_SIBS, 254, 128, 128, 254, 254, 128, 128, 254));
    send_word(make_word(REL_SIBS, 1, 2, 2, 1, 1, 2, 1, 3));
  endtask

  // Random words: mostly sib families with small allele pools, plus noise.
  task automatic test_random_families(int n_items);
    in_word_t w;
    int base;
    int roll;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      w.relation = ($urandom_range(0, 9) < 7) ? REL_SIBS : RelationW'($urandom_range(0, 7));
      base = $urandom_range(1, 252);
      w.father_allele_a = AlleleW'(base + $urandom_range(0, 3));
      w.father_allele_b = AlleleW'(base + $urandom_range(0, 3));
      w.mother_allele_a = AlleleW'(base + $urandom_range(0, 3));
      w.mother_allele_b = AlleleW'(base + $urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) begin
        // Sibs inherit one allele from each parent.
        w.first_allele_a  = $urandom_range(0, 1) ? w.father_allele_a : w.father_allele_b;
        w.first_allele_b  = $urandom_range(0, 1) ? w.mother_allele_a : w.mother_allele_b;
        w.second_allele_a = $urandom_range(0, 1) ? w.mother_allele_a : w.mother_allele_b;
        w.second_allele_b = $urandom_range(0, 1) ? w.father_allele_a : w.father_allele_b;
      end else begin
        w.first_allele_a  = AlleleW'(base + $urandom_range(0, 3));
        w.first_allele_b  = AlleleW'(base + $urandom_range(0, 3));
        w.second_allele_a = AlleleW'(base + $urandom_range(0, 3));
        w.second_allele_b = AlleleW'(base + $urandom_range(0, 3));
      end
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        w[AlleleW * $urandom_range(0, 7) +: AlleleW] = '0;
      end else if (roll == 2) begin
        for (int f = 0; f < 8; f++) w[AlleleW * f +: AlleleW] = AlleleW'($urandom_range(0, 255));
      end
      send_word(w);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fixed_relations();
    test_untyped_family();
    test_homozygous_parents();
    test_state_sharing();
    drain_results();
    test_random_families(400);
    drain_results();
    test_random_families(400);
    drain_results();

    repeat (Latency + 2) @(posedge clk_i);
    if (mismatch_count == 0 && expected_shares.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spie_pkg.sv
rtl/spie_rules.sv
rtl/sib_pair_ibd_estimate_top.sv
tb/tb.sv
